/* rtl/dbsim_pkg.sv */
// Shared constants, types and functions for the DES S-box linear approximation search.
// Holds the S-box table, the parity helper and the fill write bundle.
// No dependencies.
package dbsim_pkg;

  localparam int NBOX    = 8;
  localparam int LAT_AW  = 10;              // {input mask (6), output nibble (4)}
  localparam int LAT_DEPTH = 1 << LAT_AW;
  localparam int ENT_W   = 7;               // signed entry, -32..32
  localparam int PROD_W  = 42;

  localparam logic [3:0] SBOX [0:511] = '{
    // box 0
    4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
    4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
    4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
    4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13,
    // box 1
    4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
    4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
    4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
    4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9,
    // box 2
    4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
    4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
    4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
    4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12,
    // box 3
    4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
    4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
    4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
    4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14,
    // box 4
    4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
    4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
    4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
    4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3,
    // box 5
    4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
    4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
    4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
    4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13,
    // box 6
    4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
    4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
    4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
    4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12,
    // box 7
    4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
    4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
    4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
    4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11
  };

  // Write bundle from the fill engine to the table banks.
  typedef struct packed {
    logic                           we;
    logic [LAT_AW-1:0]              addr;
    logic [NBOX-1:0][ENT_W-1:0]     data;
  } fill_wr_t;

  // Row is x[5],x[0]; column is x[4:1].
  function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [5:0] x);
    return SBOX[{box, x[5], x[0], x[4:1]}];
  endfunction

  function automatic logic parity6(input logic [5:0] v);
    return ^v;
  endfunction

endpackage

/* rtl/dbsim_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbsim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dbsim_fill.sv */
// Post-reset fill engine: computes every approximation table entry, one x per cycle.
// Depends on dbsim_pkg.
module dbsim_fill import dbsim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  output fill_wr_t wr_o,
  output logic     done_o
);

  logic [15:0]                cnt_q;     // {a, b, x}
  logic                       done_q;
  logic [NBOX-1:0][6:0]       hits_q, hits_d;
  logic [NBOX-1:0][ENT_W-1:0] fill_data;
  logic [5:0]                 a, x;
  logic [3:0]                 b;

  assign a = cnt_q[15:10];
  assign b = cnt_q[9:6];
  assign x = cnt_q[5:0];

  always_comb begin
    for (int k = 0; k < NBOX; k++) begin
      hits_d[k] = ((x == 6'd0) ? 7'd0 : hits_q[k])
                + {6'd0, ~(parity6(a & x) ^ parity6({2'b00, b & sbox_lookup(3'(k), x)}))};
      fill_data[k] = 7'(hits_d[k] - 7'd32);
    end
  end

  assign wr_o.we   = !done_q && (x == 6'h3F);
  assign wr_o.addr = {a, b};
  assign wr_o.data = fill_data;
  assign done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (!done_q) begin
      cnt_q <= cnt_q + 16'd1;
      if (cnt_q == 16'hFFFF) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q <= hits_d;
  end

endmodule

/* rtl/dbsim_pick.sv */
// Per-box best-entry tracker: keeps the first mask with the largest absolute entry.
// Depends on dbsim_pkg.
module dbsim_pick import dbsim_pkg::*; (
  input  logic                       clk_i,
  input  logic                       clear_i,
  input  logic                       upd_i,
  input  logic [5:0]                 mask_i,
  input  logic [NBOX-1:0][ENT_W-1:0] data_i,
  output logic [NBOX-1:0][5:0]       pick_o,
  output logic [NBOX-1:0][ENT_W-1:0] val_o
);

  logic [NBOX-1:0][5:0] best_abs_q;
  logic [NBOX-1:0][5:0] av;

  always_comb begin
    for (int k = 0; k < NBOX; k++) begin
      av[k] = data_i[k][ENT_W-1] ? 6'(-data_i[k]) : 6'(data_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NBOX; k++) begin
      if (clear_i) begin
        best_abs_q[k] <= '0;
        val_o[k]      <= '0;
        pick_o[k]     <= '0;
      end else if (upd_i && (av[k] > best_abs_q[k])) begin
        // strict compare keeps the lowest mask on ties
        best_abs_q[k] <= av[k];
        val_o[k]      <= data_i[k];
        pick_o[k]     <= mask_i;
      end
    end
  end

endmodule

/* rtl/des_best_sbox_input_mask_search.sv */
// DES S-box linear approximation table with best input-mask search.
// Depends on dbsim_pkg, dbsim_ram, dbsim_fill, dbsim_pick.
//
// Usage: an item on the input channel (output_mask_i, valid/ready) is a 32-bit
// output mask, one nibble per box, box 0 in the top nibble. The result item on
// the output channel carries the packed 48-bit input mask, the active box count
// and the signed product of the chosen table entries (bias numerator).
// After reset the table (eight banks of 1024 x 7 bits) is computed, one S-box
// input per cycle for all eight banks, while in_ready_o is low. After that an
// item takes 63 bank reads (one candidate mask per cycle on each bank's read
// port), a registered read, a check that the scan has drained, a serial multiply,
// box by box, for the product, and a load of the output register. Items are
// taken one at a time: a new item is accepted only once the previous result
// has moved to the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished second result holds in the engine
// until the output register frees.
module des_best_sbox_input_mask_search import dbsim_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [31:0]              output_mask_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [47:0]              input_mask_o,
  output logic [3:0]               active_boxes_o,
  output logic signed [PROD_W-1:0] bias_numerator_o
);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [31:0]                om_q;
  logic [5:0]                 m_q;
  logic [5:0]                 rd_m_q;
  logic                       rd_vld_q;
  logic [2:0]                 k_q;
  logic signed [PROD_W-1:0]   acc_q;
  logic                       out_valid_q;

  fill_wr_t                   fill_wr;
  logic                       fill_done;
  logic [NBOX-1:0][ENT_W-1:0] rdata;
  logic [NBOX-1:0][5:0]       pick;
  logic [NBOX-1:0][ENT_W-1:0] val;
  logic [NBOX-1:0][3:0]       nib;
  logic                       in_acc, issue;
  logic signed [48:0]         prod;
  logic [47:0]                packed_mask;
  logic [3:0]                 n_active;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_SCAN) && (m_q != 6'd0);

  dbsim_fill u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (fill_wr),
    .done_o (fill_done)
  );

  always_comb begin
    for (int k = 0; k < NBOX; k++) begin
      nib[k] = om_q[(NBOX-1-k)*4 +: 4];
    end
  end

  for (genvar g = 0; g < NBOX; g++) begin : g_bank
    dbsim_ram #(
      .Width (ENT_W),
      .Depth (LAT_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (fill_wr.we),
      .waddr_i (fill_wr.addr),
      .wdata_i (fill_wr.data[g]),
      .raddr_i ({m_q, nib[g]}),
      .rdata_o (rdata[g])
    );
  end

  dbsim_pick u_pick (
    .clk_i   (clk_i),
    .clear_i (in_acc),
    .upd_i   (rd_vld_q),
    .mask_i  (rd_m_q),
    .data_i  (rdata),
    .pick_o  (pick),
    .val_o   (val)
  );

  assign prod = acc_q * $signed(val[k_q]);

  always_comb begin
    n_active = '0;
    for (int k = 0; k < NBOX; k++) begin
      packed_mask[(NBOX-1-k)*6 +: 6] = (nib[k] != 4'd0) ? pick[k] : 6'd0;
      n_active = n_active + {3'd0, (nib[k] != 4'd0)};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_FILL: if (fill_done) state_d = S_IDLE;
      S_IDLE: if (in_acc) state_d = S_SCAN;
      S_SCAN: if (m_q == 6'd0 && !rd_vld_q) state_d = S_MUL;
      S_MUL:  if (k_q == 3'd7) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      m_q         <= '0;
      rd_vld_q    <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (in_acc) begin
        m_q <= 6'd1;
        k_q <= '0;
      end else begin
        if (issue) m_q <= m_q + 6'd1;   // wraps to zero after mask 63
        if (state_q == S_MUL) k_q <= k_q + 3'd1;
      end
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_m_q <= m_q;
    if (in_acc) begin
      om_q  <= output_mask_i;
      acc_q <= PROD_W'(1);
    end else if (state_q == S_MUL && nib[k_q] != 4'd0) begin
      acc_q <= prod[PROD_W-1:0];
    end
    if (state_q == S_DONE && state_d == S_IDLE) begin
      input_mask_o     <= packed_mask;
      active_boxes_o   <= n_active;
      bias_numerator_o <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_scan_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> fill_done) else $error("scan before table fill done");
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN)) else $error("bank read outside scan");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SCAN && m_q == 6'd1)) else $error("scan did not start");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q) else $error("result not loaded");
  a_no_fill_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |-> !fill_wr.we) else $error("table write after fill");

endmodule
